// ----- hdl/dual_channel_trimmed_mean_filter_macros.svh -----
// Assertion macros for the dual-channel trimmed-mean filter.
`ifndef DUAL_CHANNEL_TRIMMED_MEAN_FILTER_MACROS_SVH
`define DUAL_CHANNEL_TRIMMED_MEAN_FILTER_MACROS_SVH

// An expression that must hold at every clock edge out of reset.
`define DCTM_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DCTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dctm_pkg.sv -----
// Shared constants and types for the dual-channel trimmed-mean filter.
package dctm_pkg;

  // Samples per block; ranks TRIM_LO..TRIM_LO+TRIM_N-1 must exist.
  localparam int SAMPLES  = 32;
  localparam int TRIM_LO  = 10;
  localparam int TRIM_N   = 10;

  localparam int SAMPLE_W = 12;
  localparam int VAL_W    = SAMPLE_W + 1;
  localparam int SUM_W    = 16;
  localparam int VOLT_W   = 18;
  localparam int CNT_W    = $clog2(SAMPLES + 1);

  // Empty marker: larger than any real sample, so it sinks to the top.
  localparam logic [VAL_W-1:0] EMPTY = {1'b1, {SAMPLE_W{1'b0}}};

  // floor(y/5) = (y * RECIP) >> RECIP_SHIFT, exact for y < 2**18.
  localparam int Y_W         = SUM_W + 2;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(209716);
  localparam int PROD_W      = Y_W + RECIP_W;

  // Register stages of the summing unit.
  localparam int PIPE_DEPTH = 3;

  typedef logic [TRIM_N-1:0][SAMPLE_W-1:0] trim_vec_t;

endpackage

// ----- hdl/dual_channel_trimmed_mean_filter.sv -----
// Top level of the dual-channel trimmed-mean filter.
//
// Input channel: in_valid/in_ready with sample_a and sample_b, one pair per item.
// Output channel: out_valid/out_ready with sum_a, sum_b, volts_a and volts_b.
// Each channel feeds a row of SAMPLES sorter cells. While a block fills, one
// pair is taken per cycle while in_valid is high, and each value ripples right
// until it finds its rank. After the last pair of a block the rows settle, then
// the summing unit (three register stages) adds ranks 10 to 19 and forms the
// voltage, and out_valid rises. A block thus passes through fill, settle,
// summing and output phases in turn; the length of the fill phase is set by the
// single cell-row insert port. in_ready is low from the last pair of a block
// until the result item is taken; a stalled receiver simply holds the result,
// since the rows and the summing unit stay frozen. Volts carry 16 fractional bits.
// Reset empties both rows and restarts block counting; no clearing pass is needed.
`include "dual_channel_trimmed_mean_filter_macros.svh"

module dual_channel_trimmed_mean_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dctm_pkg::SAMPLE_W-1:0]     sample_a,
  input  logic [dctm_pkg::SAMPLE_W-1:0]     sample_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dctm_pkg::SUM_W-1:0]        sum_a,
  output logic [dctm_pkg::SUM_W-1:0]        sum_b,
  output logic [dctm_pkg::VOLT_W-1:0]       volts_a,
  output logic [dctm_pkg::VOLT_W-1:0]       volts_b
);

  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]                  state;
  logic [dctm_pkg::CNT_W-1:0]  cnt;
  logic                        in_take;
  logic                        out_take;
  logic                        clear;

  logic [dctm_pkg::VAL_W-1:0]  link_a [dctm_pkg::SAMPLES+1];
  logic [dctm_pkg::VAL_W-1:0]  link_b [dctm_pkg::SAMPLES+1];
  logic [dctm_pkg::VAL_W-1:0]  held_a [dctm_pkg::SAMPLES];
  logic [dctm_pkg::VAL_W-1:0]  held_b [dctm_pkg::SAMPLES];
  dctm_pkg::trim_vec_t         ranks_a;
  dctm_pkg::trim_vec_t         ranks_b;

  assign in_ready  = (state == ST_FILL);
  assign out_valid = (state == ST_OUT);
  assign in_take   = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;
  assign clear     = rst || out_take;

  // New samples enter the left end; idle cycles push empty markers.
  assign link_a[0] = in_take ? {1'b0, sample_a} : dctm_pkg::EMPTY;
  assign link_b[0] = in_take ? {1'b0, sample_b} : dctm_pkg::EMPTY;

  // Two rows of sorter cells, one per channel.
  for (genvar i = 0; i < dctm_pkg::SAMPLES; i++) begin : g_row
    dctm_cell u_cell_a (
      .clk   (clk),
      .clear (clear),
      .din   (link_a[i]),
      .held  (held_a[i]),
      .dout  (link_a[i+1])
    );
    dctm_cell u_cell_b (
      .clk   (clk),
      .clear (clear),
      .din   (link_b[i]),
      .held  (held_b[i]),
      .dout  (link_b[i+1])
    );
  end

  // Tap the cells that hold the trimmed ranks.
  always_comb begin
    for (int k = 0; k < dctm_pkg::TRIM_N; k++) begin
      ranks_a[k] = held_a[dctm_pkg::TRIM_LO + k][dctm_pkg::SAMPLE_W-1:0];
      ranks_b[k] = held_b[dctm_pkg::TRIM_LO + k][dctm_pkg::SAMPLE_W-1:0];
    end
  end

  dctm_reduce u_reduce_a (
    .clk   (clk),
    .ranks (ranks_a),
    .sum   (sum_a),
    .volts (volts_a)
  );

  dctm_reduce u_reduce_b (
    .clk   (clk),
    .ranks (ranks_b),
    .sum   (sum_b),
    .volts (volts_b)
  );

  // Block sequencer: fill, let the rows settle, run the summing unit, offer the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      cnt   <= '0;
    end else begin
      case (state)
        ST_FILL: begin
          if (in_take) begin
            if (cnt == dctm_pkg::CNT_W'(dctm_pkg::SAMPLES - 1)) begin
              state <= ST_DRAIN;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (cnt == dctm_pkg::CNT_W'(dctm_pkg::SAMPLES - 1)) begin
            state <= ST_SUM;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SUM: begin
          if (cnt == dctm_pkg::CNT_W'(dctm_pkg::PIPE_DEPTH - 1)) begin
            state <= ST_OUT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_FILL;
          end
        end
        default: begin
          state <= ST_FILL;
          cnt   <= '0;
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `DCTM_ASSERT_ALWAYS(a_one_side, clk, rst, !(in_ready && out_valid), "input and output both open")
  `DCTM_ASSERT_ALWAYS(a_fill_bound, clk, rst, !(state == ST_FILL) || (cnt < dctm_pkg::CNT_W'(dctm_pkg::SAMPLES)), "fill count past block size")
  `DCTM_ASSERT_NEXT(a_restart, clk, rst, out_take, in_ready && !out_valid, "no new block after result taken")

endmodule

// ----- hdl/dctm_cell.sv -----
// One cell of the systolic insertion sorter: keeps the smaller value, passes the larger.
module dctm_cell (
  input  logic                          clk,
  input  logic                          clear,
  input  logic [dctm_pkg::VAL_W-1:0]    din,
  output logic [dctm_pkg::VAL_W-1:0]    held,
  output logic [dctm_pkg::VAL_W-1:0]    dout
);

  // Compare the arriving value with the held one and hand the larger to the right.
  always_ff @(posedge clk) begin
    if (clear) begin
      held <= dctm_pkg::EMPTY;
      dout <= dctm_pkg::EMPTY;
    end else if (din < held) begin
      held <= din;
      dout <= held;
    end else begin
      dout <= din;
    end
  end

endmodule

// ----- hdl/dctm_reduce.sv -----
// Trimmed sum and fixed-point voltage pipeline for one channel.
module dctm_reduce (
  input  logic                           clk,
  input  dctm_pkg::trim_vec_t            ranks,
  output logic [dctm_pkg::SUM_W-1:0]     sum,
  output logic [dctm_pkg::VOLT_W-1:0]    volts
);

  localparam int PAIRS  = dctm_pkg::TRIM_N / 2;
  localparam int PAIR_W = dctm_pkg::SAMPLE_W + 1;

  logic [PAIR_W-1:0]                 pair_sum [PAIRS];
  logic [dctm_pkg::SUM_W-1:0]        total;
  logic [dctm_pkg::SUM_W-1:0]        total_next;
  logic [dctm_pkg::SUM_W-1:0]        sum_q;
  logic [dctm_pkg::Y_W-1:0]          y;
  logic [dctm_pkg::PROD_W-1:0]       prod;
  logic [dctm_pkg::SUM_W-1:0]        quot;

  // First stage: add neighboring ranks in pairs.
  always_ff @(posedge clk) begin
    for (int p = 0; p < PAIRS; p++) begin
      pair_sum[p] <= PAIR_W'(ranks[2*p]) + PAIR_W'(ranks[2*p+1]);
    end
  end

  // Second stage: add the pair sums.
  always_comb begin
    total_next = '0;
    for (int p = 0; p < PAIRS; p++) begin
      total_next = total_next + dctm_pkg::SUM_W'(pair_sum[p]);
    end
  end

  always_ff @(posedge clk) begin
    total <= total_next;
  end

  // Third stage: sum*24/5 = 4*sum + floor(4*sum/5), the division done by reciprocal.
  assign y    = {total, 2'b00};
  assign prod = dctm_pkg::PROD_W'(y) * dctm_pkg::PROD_W'(dctm_pkg::RECIP);

  always_ff @(posedge clk) begin
    sum_q <= total;
    quot  <= prod[dctm_pkg::RECIP_SHIFT +: dctm_pkg::SUM_W];
  end

  assign sum   = sum_q;
  assign volts = dctm_pkg::VOLT_W'({sum_q, 2'b00}) + dctm_pkg::VOLT_W'(quot);

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the dual-channel trimmed-mean filter.
module tb_top;

  // One sample pair as queued for the driver.
  typedef struct {
    logic [dctm_pkg::SAMPLE_W-1:0] a;
    logic [dctm_pkg::SAMPLE_W-1:0] b;
    bit                            drain_first;
  } sample_pair_t;

  // One block result as predicted.
  typedef struct {
    logic [dctm_pkg::SUM_W-1:0]  sum_a;
    logic [dctm_pkg::SUM_W-1:0]  sum_b;
    logic [dctm_pkg::VOLT_W-1:0] volts_a;
    logic [dctm_pkg::VOLT_W-1:0] volts_b;
  } block_result_t;

  typedef logic [dctm_pkg::SAMPLE_W-1:0] sample_block_t [dctm_pkg::SAMPLES];

  typedef enum int {
    PAT_FLAT,
    PAT_UNIFORM,
    PAT_CLUSTER,
    PAT_EXTREMES,
    PAT_RAMP
  } block_pattern_t;

  localparam int SAMPLE_MAX = (1 << dctm_pkg::SAMPLE_W) - 1;
  localparam int IDLE_PCT   = 17;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [dctm_pkg::SAMPLE_W-1:0] sample_a  = '0;
  logic [dctm_pkg::SAMPLE_W-1:0] sample_b  = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dctm_pkg::SUM_W-1:0]    sum_a;
  logic [dctm_pkg::SUM_W-1:0]    sum_b;
  logic [dctm_pkg::VOLT_W-1:0]   volts_a;
  logic [dctm_pkg::VOLT_W-1:0]   volts_b;

  sample_pair_t  pending_pairs[$];
  block_result_t expected_results[$];

  // Predictor state: the samples of the block being filled.
  sample_block_t block_a;
  sample_block_t block_b;
  int            block_fill     = 0;

  int            pairs_accepted = 0;
  int            results_seen   = 0;
  int            error_count    = 0;
  bit            pair_taken     = 1'b0;

  dual_channel_trimmed_mean_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_a  (sample_a),
    .sample_b  (sample_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_a     (sum_a),
    .sum_b     (sum_b),
    .volts_a   (volts_a),
    .volts_b   (volts_b)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t, %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sorts a block ascending and adds the samples at ranks TRIM_LO..TRIM_LO+TRIM_N-1.
  function automatic logic [dctm_pkg::SUM_W-1:0] trimmed_total(input sample_block_t blk);
    logic [dctm_pkg::SAMPLE_W-1:0] x;
    int                            k;
    int                            total;
    total = 0;
    for (int i = 1; i < dctm_pkg::SAMPLES; i++) begin
      x = blk[i];
      k = i;
      while (k > 0 && blk[k-1] > x) begin
        blk[k] = blk[k-1];
        k--;
      end
      blk[k] = x;
    end
    for (int i = 0; i < dctm_pkg::TRIM_N; i++) total += blk[dctm_pkg::TRIM_LO + i];
    return dctm_pkg::SUM_W'(total);
  endfunction

  // Mean voltage with 16 fractional bits: sum/10 * 3/4096, rounded down.
  function automatic logic [dctm_pkg::VOLT_W-1:0] mean_volts(
      input logic [dctm_pkg::SUM_W-1:0] total);
    int unsigned scaled;
    scaled = (int'(total) * 24) / 5;
    return dctm_pkg::VOLT_W'(scaled);
  endfunction

  // Takes one accepted pair; at the end of a block, queues the block result.
  task automatic absorb_pair(input logic [dctm_pkg::SAMPLE_W-1:0] a,
                             input logic [dctm_pkg::SAMPLE_W-1:0] b);
    block_result_t res;
    block_a[block_fill] = a;
    block_b[block_fill] = b;
    block_fill++;
    if (block_fill == dctm_pkg::SAMPLES) begin
      block_fill  = 0;
      res.sum_a   = trimmed_total(block_a);
      res.sum_b   = trimmed_total(block_b);
      res.volts_a = mean_volts(res.sum_a);
      res.volts_b = mean_volts(res.sum_b);
      expected_results.push_back(res);
    end
  endtask

  // Appends one block of sample pairs shaped by the given pattern.
  task automatic queue_block(input block_pattern_t pat, input bit drain_first,
                             input int base_a, input int base_b);
    sample_pair_t p;
    int           step;
    int           jitter_a;
    int           jitter_b;
    step = (SAMPLE_MAX + 1) / dctm_pkg::SAMPLES;
    for (int i = 0; i < dctm_pkg::SAMPLES; i++) begin
      p.drain_first = drain_first && (i == 0);
      case (pat)
        PAT_FLAT: begin
          p.a = dctm_pkg::SAMPLE_W'(base_a);
          p.b = dctm_pkg::SAMPLE_W'(base_b);
        end
        PAT_UNIFORM: begin
          p.a = dctm_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX));
          p.b = dctm_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX));
        end
        PAT_CLUSTER: begin
          // Narrow spread around a base value, so many samples are equal.
          jitter_a = base_a + int'($urandom_range(3));
          jitter_b = base_b + int'($urandom_range(3));
          p.a = dctm_pkg::SAMPLE_W'((jitter_a > SAMPLE_MAX) ? SAMPLE_MAX : jitter_a);
          p.b = dctm_pkg::SAMPLE_W'((jitter_b > SAMPLE_MAX) ? SAMPLE_MAX : jitter_b);
        end
        PAT_EXTREMES: begin
          p.a = $urandom_range(1) ? dctm_pkg::SAMPLE_W'(SAMPLE_MAX) : '0;
          p.b = $urandom_range(1) ? dctm_pkg::SAMPLE_W'(SAMPLE_MAX) : '0;
        end
        default: begin
          // Channel A rises and channel B falls across the block.
          p.a = dctm_pkg::SAMPLE_W'(i * step + $urandom_range(step - 1));
          p.b = dctm_pkg::SAMPLE_W'(SAMPLE_MAX - i * step - $urandom_range(step - 1));
        end
      endcase
      pending_pairs.push_back(p);
    end
  endtask

  // The sender idles at random except during a calm stretch of the run.
  function automatic bit sender_idles();
    if (pairs_accepted >= 320 && pairs_accepted < 704) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // The receiver stalls at random except during a calm stretch of results.
  function automatic bit receiver_stalls();
    if (results_seen >= 10 && results_seen < 22) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Driver: presents the next queued pair at the falling edge.
  always @(negedge clk) begin : drive_pairs
    sample_pair_t nxt;
    if (!rst && (!in_valid || pair_taken)) begin
      if (pending_pairs.size() != 0 && !sender_idles() &&
          !(pending_pairs[0].drain_first && expected_results.size() != 0)) begin
        nxt = pending_pairs.pop_front();
        in_valid <= 1'b1;
        sample_a <= nxt.a;
        sample_b <= nxt.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
    pair_taken = 1'b0;
  end

  // Receiver readiness changes at the falling edge.
  always @(negedge clk) begin : drive_ready
    out_ready <= !receiver_stalls();
  end

  // Monitor: checks results and feeds accepted pairs to the predictor.
  always @(posedge clk) begin : watch_channels
    block_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result item with none expected", int'(sum_a), -1);
        end else begin
          want = expected_results.pop_front();
          if (sum_a !== want.sum_a) report_mismatch("sum_a", sum_a, want.sum_a);
          if (sum_b !== want.sum_b) report_mismatch("sum_b", sum_b, want.sum_b);
          if (volts_a !== want.volts_a) report_mismatch("volts_a", volts_a, want.volts_a);
          if (volts_b !== want.volts_b) report_mismatch("volts_b", volts_b, want.volts_b);
        end
      end
      if (in_valid && in_ready) begin
        pair_taken = 1'b1;
        pairs_accepted++;
        absorb_pair(sample_a, sample_b);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    int pick;
    int guard;

    // Directed blocks: full-scale and zero sums, every sample equal.
    queue_block(PAT_FLAT, 1'b0, SAMPLE_MAX, 0);
    queue_block(PAT_FLAT, 1'b0, 0, SAMPLE_MAX);

    // Random blocks; two of them wait for all results before starting.
    for (int n = 0; n < 39; n++) begin
      pick = $urandom_range(9);
      queue_block(pick < 5 ? PAT_UNIFORM : pick < 7 ? PAT_CLUSTER :
                  pick < 8 ? PAT_EXTREMES : PAT_RAMP,
                  n == 12 || n == 27,
                  $urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    for (guard = 0; guard < 20000 && expected_results.size() != 0; guard++) @(posedge clk);
    repeat (dctm_pkg::SAMPLES + dctm_pkg::PIPE_DEPTH + 8) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("result items never arrived", 0, expected_results.size());

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin : run_limit
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- dual_channel_trimmed_mean_filter.f -----
+incdir+hdl
hdl/dctm_pkg.sv
hdl/dctm_cell.sv
hdl/dctm_reduce.sv
hdl/dual_channel_trimmed_mean_filter.sv
test/tb_top.sv
